FILE: rtl/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// shared constants for the lru tag store: default geometry, register reset,
// lookup opcodes
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int LTS_ENTRIES  = 64;
  localparam int LTS_KEY_BITS = 16;

  localparam int          CAP_BITS  = 7;
  localparam int          CNT_WIDTH = 32;
  localparam logic [6:0]  CAP_RESET = 7'd64;

  typedef enum logic {
    OP_LOOKUP     = 1'b0,
    OP_INVALIDATE = 1'b1
  } lts_op_t;

endpackage

FILE: rtl/lru_tag_store.sv
// ----------------------------------------------------------------------------
// lru_tag_store
// fully associative lru tag store built as a chain of rank cells
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): one beat carries op and key. a lookup
//   (op = 0) searches every held id; a hit moves it to most recent, a miss
//   inserts it as most recent in the lowest free slot, or in the slot of the
//   least recent id when the store is at capacity, which is then evicted.
//   an invalidate (op = 1) empties the store and keeps the running counters.
//   output channel (out_valid/out_ready): exactly one result beat per input.
//   configuration: cfg_we writes cfg_wdata into capacity (0 acts as 1, above
//   ENTRIES acts as ENTRIES); write only while the block is idle.
//   throughput: one item per cycle while the receiver does not stall; each
//   item passes through the probe register, where the cell compare, encode
//   and shift of the rank chain run, and then into the result registers.
//   stall: while a result waits on out_ready the probe holds, and in_ready
//   drops once the probe is also occupied.
//   reset: counters and held count go to zero, capacity to 64; no clearing
//   pass, entries above the held count are never looked at.
// ----------------------------------------------------------------------------
module lru_tag_store #(
  parameter int ENTRIES  = lts_pkg::LTS_ENTRIES,
  parameter int KEY_BITS = lts_pkg::LTS_KEY_BITS,
  localparam int SLOT_BITS = $clog2(ENTRIES),
  localparam int CNT_BITS  = $clog2(ENTRIES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [lts_pkg::CAP_BITS-1:0]  cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [KEY_BITS-1:0]           key,
  // output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic [SLOT_BITS-1:0]          slot,
  output logic                          evicted_valid,
  output logic [KEY_BITS-1:0]           evicted_key,
  output logic [CNT_BITS-1:0]           entries_held,
  output logic [lts_pkg::CNT_WIDTH-1:0] request_count,
  output logic [lts_pkg::CNT_WIDTH-1:0] hit_count,
  output logic [lts_pkg::CNT_WIDTH-1:0] eviction_count
);

  import lts_pkg::*;

  // width wide enough for both the capacity register and the entry count
  localparam int CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

  // configuration register
  logic [CAP_BITS-1:0] capacity;

  // probe register: the item being worked on
  logic                busy;
  lts_op_t             p_op;
  logic [KEY_BITS-1:0] p_key;
  logic                go;

  // held count doubles as the entries_held output
  logic [CNT_BITS-1:0] held;
  logic [CNT_BITS-1:0] held_next;

  // rank chain taps
  logic [KEY_BITS-1:0]  cell_key  [ENTRIES];
  logic [SLOT_BITS-1:0] cell_slot [ENTRIES];
  logic [ENTRIES-1:0]   match;

  // decision logic
  logic                 any_hit;
  logic [SLOT_BITS-1:0] found_rank;
  logic [SLOT_BITS-1:0] hit_slot;
  logic [KEY_BITS-1:0]  tail_key;
  logic [SLOT_BITS-1:0] tail_slot;
  logic [CNT_BITS-1:0]  held_m1;
  logic [CMP_BITS-1:0]  cap_ext;
  logic [CMP_BITS-1:0]  eff_cap;
  logic                 evict;
  logic [SLOT_BITS-1:0] free_slot;
  logic [SLOT_BITS-1:0] new_slot;
  logic [CNT_BITS-1:0]  limit;
  logic                 lookup;
  logic                 update;

  // ---------------------------------------------------------------- handshake
  // the probe moves on when the output register is empty or being drained
  assign go       = busy && (!out_valid || out_ready);
  assign in_ready = !busy || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
    end else if (go) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      p_op  <= lts_op_t'(op);
      p_key <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------- rank chain
  // cell 0 takes the probe key and its chosen slot, each later cell up to
  // the limit rank its more recent neighbor, so a move-to-front is one shift
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic [KEY_BITS-1:0]  prev_key;
    logic [SLOT_BITS-1:0] prev_slot;

    if (g == 0) begin : g_head
      assign prev_key  = p_key;
      assign prev_slot = new_slot;
    end else begin : g_link
      assign prev_key  = cell_key[g-1];
      assign prev_slot = cell_slot[g-1];
    end

    lts_cell #(
      .IDX       (g),
      .KEY_BITS  (KEY_BITS),
      .SLOT_BITS (SLOT_BITS),
      .CNT_BITS  (CNT_BITS)
    ) u_cell (
      .clk       (clk),
      .probe_key (p_key),
      .held      (held),
      .update    (update),
      .limit     (limit),
      .prev_key  (prev_key),
      .prev_slot (prev_slot),
      .cell_key  (cell_key[g]),
      .cell_slot (cell_slot[g]),
      .match     (match[g])
    );
  end

  // ---------------------------------------------------------------- decisions
  assign held_m1 = held - CNT_BITS'(1);

  // keys are unique in the store, so match is one-hot or zero and the
  // rank and slot of the hit fall out of plain or-reductions
  always_comb begin
    found_rank = '0;
    hit_slot   = '0;
    tail_key   = '0;
    tail_slot  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        found_rank = found_rank | SLOT_BITS'(i);
        hit_slot   = hit_slot | cell_slot[i];
      end
      // least recent rank sits right below the held count
      if (held_m1 == CNT_BITS'(i)) begin
        tail_key  = tail_key | cell_key[i];
        tail_slot = tail_slot | cell_slot[i];
      end
    end
  end

  assign any_hit = |match;

  // capacity zero acts as one, above the entry count as the entry count
  assign cap_ext = CMP_BITS'(capacity);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CMP_BITS'(1);
    end else if (cap_ext > CMP_BITS'(ENTRIES)) begin
      eff_cap = CMP_BITS'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // a miss at or over capacity reclaims the least recent entry, once
  assign evict = !any_hit && (CMP_BITS'(held) >= eff_cap);

  lts_slot_map #(
    .ENTRIES   (ENTRIES),
    .SLOT_BITS (SLOT_BITS)
  ) u_slot_map (
    .clk       (clk),
    .rst       (rst),
    .clear     (go && (p_op == OP_INVALIDATE)),
    .set_en    (update && !any_hit && !evict),
    .set_slot  (free_slot),
    .free_slot (free_slot)
  );

  always_comb begin
    if (any_hit) begin
      new_slot = hit_slot;
    end else if (evict) begin
      new_slot = tail_slot;
    end else begin
      new_slot = free_slot;
    end
  end

  // deepest rank that shifts: the hit rank, one below the held count on eviction, else the held count
  always_comb begin
    if (any_hit) begin
      limit = CNT_BITS'(found_rank);
    end else if (evict) begin
      limit = held_m1;
    end else begin
      limit = held;
    end
  end

  assign lookup = (p_op == OP_LOOKUP);
  assign update = go && lookup;

  always_comb begin
    if (!lookup) begin
      held_next = '0;
    end else if (any_hit || evict) begin
      held_next = held;
    end else begin
      held_next = held + CNT_BITS'(1);
    end
  end

  // ---------------------------------------------------------------- counters
  // these only change when a result is loaded, so they serve as the
  // output payload directly and hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      held           <= '0;
      request_count  <= '0;
      hit_count      <= '0;
      eviction_count <= '0;
    end else if (go) begin
      held <= held_next;
      if (lookup) begin
        request_count <= request_count + CNT_WIDTH'(1);
      end
      if (lookup && any_hit) begin
        hit_count <= hit_count + CNT_WIDTH'(1);
      end
      if (lookup && evict) begin
        eviction_count <= eviction_count + CNT_WIDTH'(1);
      end
    end
  end

  assign entries_held = held;

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (lookup) begin
        hit           <= any_hit;
        slot          <= new_slot;
        evicted_valid <= evict;
        evicted_key   <= evict ? tail_key : '1;
      end else begin
        // invalidate beat
        hit           <= 1'b0;
        slot          <= '0;
        evicted_valid <= 1'b0;
        evicted_key   <= '1;
      end
    end
  end

endmodule

FILE: rtl/lts_cell.sv
// ----------------------------------------------------------------------------
// lts_cell
// one recency rank of the tag store: holds a key and its slot, compares the
// probe key, and takes its upper neighbor's contents on a move-to-front
// ----------------------------------------------------------------------------
module lts_cell #(
  parameter int IDX       = 0,
  parameter int KEY_BITS  = 16,
  parameter int SLOT_BITS = 6,
  parameter int CNT_BITS  = 7
) (
  input  logic                 clk,
  input  logic [KEY_BITS-1:0]  probe_key,
  input  logic [CNT_BITS-1:0]  held,
  input  logic                 update,
  input  logic [CNT_BITS-1:0]  limit,
  input  logic [KEY_BITS-1:0]  prev_key,
  input  logic [SLOT_BITS-1:0] prev_slot,
  output logic [KEY_BITS-1:0]  cell_key,
  output logic [SLOT_BITS-1:0] cell_slot,
  output logic                 match
);

  import lts_pkg::*;

  localparam logic [CNT_BITS-1:0] RANK = CNT_BITS'(IDX);

  logic occupied;

  // rank is live only below the held count
  assign occupied = RANK < held;
  assign match    = occupied && (cell_key == probe_key);

  // shift one place toward least recent when at or below the limit rank
  always_ff @(posedge clk) begin
    if (update && (RANK <= limit)) begin
      cell_key  <= prev_key;
      cell_slot <= prev_slot;
    end
  end

endmodule

FILE: rtl/lts_slot_map.sv
// ----------------------------------------------------------------------------
// lts_slot_map
// occupancy bitmap of the storage slots with a lowest-free-slot encoder
// ----------------------------------------------------------------------------
module lts_slot_map #(
  parameter int ENTRIES   = 64,
  parameter int SLOT_BITS = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 set_en,
  input  logic [SLOT_BITS-1:0] set_slot,
  output logic [SLOT_BITS-1:0] free_slot
);

  import lts_pkg::*;

  logic [ENTRIES-1:0] used;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      used <= '0;
    end else if (set_en) begin
      used[set_slot] <= 1'b1;
    end
  end

  // lowest clear bit, scanning from the top so the lowest one wins
  always_comb begin
    free_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_slot = SLOT_BITS'(i);
      end
    end
  end

endmodule

FILE: verif/lts_tb_pkg.sv
// ----------------------------------------------------------------------------
// lts_tb_pkg
// response record and scoreboard for the lru tag store testbench; keeps its
// own recency list, held count, capacity and running totals
// ----------------------------------------------------------------------------
package lts_tb_pkg;

  import lts_pkg::*;

  localparam int SLOT_W = $clog2(LTS_ENTRIES);
  localparam int HELD_W = $clog2(LTS_ENTRIES + 1);

  typedef struct packed {
    logic                    hit;
    logic [SLOT_W-1:0]       slot;
    logic                    evicted_valid;
    logic [LTS_KEY_BITS-1:0] evicted_key;
    logic [HELD_W-1:0]       entries_held;
    logic [CNT_WIDTH-1:0]    request_count;
    logic [CNT_WIDTH-1:0]    hit_count;
    logic [CNT_WIDTH-1:0]    eviction_count;
  } lts_response_t;

  class lru_scoreboard;
    // rank 0 is most recent, rank held-1 least recent
    logic [LTS_KEY_BITS-1:0] rank_key [LTS_ENTRIES];
    logic [SLOT_W-1:0]       rank_slot[LTS_ENTRIES];
    int unsigned             held;
    logic [CAP_BITS-1:0]     capacity;
    logic [CNT_WIDTH-1:0]    n_req;
    logic [CNT_WIDTH-1:0]    n_hit;
    logic [CNT_WIDTH-1:0]    n_evict;
    int unsigned             n_flush;
    int unsigned             n_checked;
    int unsigned             n_bad;
    lts_response_t           responses_due[$];

    function new();
      foreach (rank_key[i]) begin
        rank_key[i]  = '0;
        rank_slot[i] = '0;
      end
      held      = 0;
      capacity  = CAP_RESET;
      n_req     = '0;
      n_hit     = '0;
      n_evict   = '0;
      n_flush   = 0;
      n_checked = 0;
      n_bad     = 0;
    endfunction

    function void set_capacity(logic [CAP_BITS-1:0] value);
      capacity = value;
    endfunction

    // one access against the recency list; returns the response it causes
    function lts_response_t lru_access(lts_op_t kind, logic [LTS_KEY_BITS-1:0] id);
      lts_response_t r;
      int            found;
      int            p;
      int            room;
      int            last;
      bit            used[LTS_ENTRIES];
      r = '0;
      r.evicted_key = '1;
      if (kind == OP_INVALIDATE) begin
        held = 0;
        n_flush++;
      end else begin
        n_req++;
        found = -1;
        for (p = 0; p < int'(held) && found < 0; p++)
          if (rank_key[p] == id) found = p;
        if (found >= 0) begin
          r.hit = 1'b1;
          n_hit++;
          r.slot = rank_slot[found];
          for (p = found; p > 0; p--) begin
            rank_key[p]  = rank_key[p-1];
            rank_slot[p] = rank_slot[p-1];
          end
        end else begin
          room = (capacity == 0) ? 1 : (capacity > LTS_ENTRIES) ? LTS_ENTRIES : int'(capacity);
          if (held > 0 && int'(held) + 1 > room) begin
            // full: the least recent id gives up its slot
            last = int'(held) - 1;
            r.evicted_valid = 1'b1;
            r.evicted_key   = rank_key[last];
            r.slot          = rank_slot[last];
            held            = last;
            n_evict++;
          end else begin
            foreach (used[i]) used[i] = 1'b0;
            for (p = 0; p < int'(held); p++) used[rank_slot[p]] = 1'b1;
            for (p = LTS_ENTRIES - 1; p >= 0; p--)
              if (!used[p]) r.slot = SLOT_W'(p);
          end
          for (p = int'(held); p > 0; p--) begin
            if (p < LTS_ENTRIES) begin
              rank_key[p]  = rank_key[p-1];
              rank_slot[p] = rank_slot[p-1];
            end
          end
          if (held < LTS_ENTRIES) held++;
        end
        rank_key[0]  = id;
        rank_slot[0] = r.slot;
      end
      r.entries_held   = HELD_W'(held);
      r.request_count  = n_req;
      r.hit_count      = n_hit;
      r.eviction_count = n_evict;
      return r;
    endfunction

    function void note_request(lts_op_t kind, logic [LTS_KEY_BITS-1:0] id);
      responses_due.push_back(lru_access(kind, id));
    endfunction

    function bit field_bad(string name, logic [31:0] want, logic [31:0] got);
      if (want === got) return 1'b0;
      if (n_bad < 10) $display("  %s: expected %0h, got %0h", name, want, got);
      return 1'b1;
    endfunction

    function void check_response(lts_response_t got);
      lts_response_t want;
      bit            bad;
      if (responses_due.size() == 0) begin
        if (n_bad < 10) $display("response beat with none outstanding: %h", got);
        n_bad++;
        return;
      end
      want = responses_due.pop_front();
      if (n_bad < 10 && got !== want)
        $display("mismatch on response %0d:", n_checked);
      bad = 1'b0;
      bad |= field_bad("hit",            want.hit,            got.hit);
      bad |= field_bad("slot",           want.slot,           got.slot);
      bad |= field_bad("evicted_valid",  want.evicted_valid,  got.evicted_valid);
      bad |= field_bad("evicted_key",    want.evicted_key,    got.evicted_key);
      bad |= field_bad("entries_held",   want.entries_held,   got.entries_held);
      bad |= field_bad("request_count",  want.request_count,  got.request_count);
      bad |= field_bad("hit_count",      want.hit_count,      got.hit_count);
      bad |= field_bad("eviction_count", want.eviction_count, got.eviction_count);
      if (bad) n_bad++;
      n_checked++;
    endfunction

    function int unsigned outstanding();
      return responses_due.size();
    endfunction
  endclass

endpackage

FILE: verif/lru_tag_store_tb.sv
// ----------------------------------------------------------------------------
// lru_tag_store_tb
// drives lookups and invalidates into the lru tag store under several
// capacities and idling mixes, predicts every response beat with its own
// recency list and compares each one field by field
// ----------------------------------------------------------------------------
module lru_tag_store_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import lts_pkg::*;
  import lts_tb_pkg::*;

  // generous, even for the slow mixes
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_MAX    = 96;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CAP_BITS-1:0]       cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  lts_op_t                   op = OP_LOOKUP;
  logic [LTS_KEY_BITS-1:0]   key = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      hit;
  logic [SLOT_W-1:0]         slot;
  logic                      evicted_valid;
  logic [LTS_KEY_BITS-1:0]   evicted_key;
  logic [HELD_W-1:0]         entries_held;
  logic [CNT_WIDTH-1:0]      request_count;
  logic [CNT_WIDTH-1:0]      hit_count;
  logic [CNT_WIDTH-1:0]      eviction_count;

  lru_scoreboard             sb;

  // handshake bookkeeping: beats sent is owned by the stimulus process,
  // responses seen by the monitor
  int unsigned               beats_sent = 0;
  int unsigned               responses_seen = 0;
  int unsigned               cycle_count = 0;

  // idling knobs, percent of cycles
  int unsigned               tx_idle_pct = 0;
  int unsigned               rx_stall_pct = 0;

  // ids drawn by the random part; small pools give hits, spill-over gives misses
  logic [LTS_KEY_BITS-1:0]   key_pool[POOL_MAX];
  int                        pool_size = 1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lru_tag_store dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .key            (key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .slot           (slot),
    .evicted_valid  (evicted_valid),
    .evicted_key    (evicted_key),
    .entries_held   (entries_held),
    .request_count  (request_count),
    .hit_count      (hit_count),
    .eviction_count (eviction_count)
  );

  // receiver: random backpressure at the current stall rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // monitor: sample both channels at the edge, before any driven update lands
  always @(posedge clk) begin : watch
    lts_response_t got;
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(op, key);
      if (out_valid && out_ready) begin
        got.hit            = hit;
        got.slot           = slot;
        got.evicted_valid  = evicted_valid;
        got.evicted_key    = evicted_key;
        got.entries_held   = entries_held;
        got.request_count  = request_count;
        got.hit_count      = hit_count;
        got.eviction_count = eviction_count;
        sb.check_response(got);
        responses_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats sent, %0d responses seen",
               cycle_count, beats_sent, responses_seen);
      $display("lru_tag_store_tb: errors");
      $finish;
    end
  end

  // one input beat; random idle cycles ahead of it, then hold until taken
  task automatic send_beat(input lts_op_t kind, input logic [LTS_KEY_BITS-1:0] id);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= kind;
    key      <= id;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic lookup(input logic [LTS_KEY_BITS-1:0] id);
    send_beat(OP_LOOKUP, id);
  endtask

  task automatic flush_store();
    send_beat(OP_INVALIDATE, LTS_KEY_BITS'($urandom_range(0, 16'hFFFF)));
  endtask

  // sender goes quiet until every response is back; the block is then idle
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (responses_seen < beats_sent) @(posedge clk);
  endtask

  // only called with the block drained
  task automatic write_capacity(input logic [CAP_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_capacity(value);
  endtask

  // 0: no idling, 1: sender idle, 2: receiver stalls, 3: light idling on both
  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 52; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 52; end
      default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
    endcase
  endtask

  // pool a little larger than the store so hits and evictions both happen
  task automatic fill_pool(input logic [CAP_BITS-1:0] value);
    int room;
    room = (value == 0) ? 1 : (value > LTS_ENTRIES) ? LTS_ENTRIES : int'(value);
    pool_size = room + 2 + $urandom_range(room / 4 + 2);
    if (pool_size > POOL_MAX) pool_size = POOL_MAX;
    foreach (key_pool[i]) key_pool[i] = LTS_KEY_BITS'($urandom_range(0, 16'hFFFF));
    // all-ones id is an ordinary key
    if ($urandom_range(1) == 1) key_pool[0] = '1;
  endtask

  initial begin
    logic [CAP_BITS-1:0] phase_cap[8];
    int                  ph;
    int                  i;
    int                  n;
    int                  roll;
    sb = new();
    phase_cap = '{7'd64, 7'd2, 7'd127, 7'd0, 7'd1, 7'd0, 7'd9, 7'd64};
    phase_cap[5] = CAP_BITS'($urandom_range(3, 63));
    set_idle_mode(0);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: key extremes, hits, invalidate, reset capacity
    lookup(16'h0000);
    lookup(16'hFFFF);
    lookup(16'h5555);
    lookup(16'hAAAA);
    lookup(16'h0000);
    lookup(16'hFFFF);
    flush_store();
    lookup(16'hAAAA);
    lookup(16'h5555);
    lookup(16'h00FF);
    lookup(16'hFF00);

    // capacity lowered below the held count: one eviction per miss
    wait_drain();
    write_capacity(7'd1);
    lookup(16'h1234);
    lookup(16'h1234);
    lookup(16'h5555);

    // capacity zero acts as one; invalidate then miss into an empty store
    wait_drain();
    write_capacity(7'd0);
    lookup(16'hFFFF);
    lookup(16'hFFFF);
    flush_store();
    lookup(16'h0001);
    lookup(16'h0002);

    // capacity above the entry count acts as the entry count
    wait_drain();
    write_capacity(7'd127);
    lookup(16'h8000);
    lookup(16'h4000);
    lookup(16'h0002);
    lookup(16'h7FFF);
    flush_store();
    lookup(16'h0000);

    // random phases, each with its own capacity, pool and idling mix;
    // the 64 -> 2 step lowers capacity under a well-filled store
    for (ph = 0; ph < 8; ph++) begin
      wait_drain();
      write_capacity(phase_cap[ph]);
      set_idle_mode(ph % 4);
      fill_pool(phase_cap[ph]);
      n = (ph == 0) ? 140 : 80;
      for (i = 0; i < n; i++) begin
        // in odd phases the sender waits mid-phase for the store to drain completely
        if (i == n / 2 && ph % 2 == 1) wait_drain();
        roll = $urandom_range(99);
        if (roll < 2)
          flush_store();
        else if (roll < 84)
          lookup(key_pool[$urandom_range(pool_size - 1)]);
        else
          lookup(LTS_KEY_BITS'($urandom_range(0, 16'hFFFF)));
      end
    end

    wait_drain();
    rx_stall_pct = 0;
    // catch any stray beat past the last expected one
    repeat (8) @(posedge clk);

    if (sb.outstanding() != 0)
      $display("%0d expected responses never arrived", sb.outstanding());
    $display("covered %0d lookups with %0d hits and %0d evictions, %0d invalidates",
             sb.n_req, sb.n_hit, sb.n_evict, sb.n_flush);
    $display("capacities 64, 1, 0, 127, 2, 9 and %0d under four idling mixes; %0d bad",
             phase_cap[5], sb.n_bad);
    if (sb.n_bad == 0 && sb.outstanding() == 0)
      $display("lru_tag_store_tb: clean");
    else
      $display("lru_tag_store_tb: errors");
    $finish;
  end

endmodule
